// ===== sv/catt_pkg.sv =====
// Shared types and constants for the constant-acceleration travel time core.
`timescale 1ns / 1ps
package catt_pkg;

	localparam int EPS_W = 17;
	localparam logic [EPS_W-1:0] EPS_RESET = 17'd66;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;
	localparam int SQ_STEPS = 32;

	typedef struct packed {
		logic signed [31:0] velocity;
		logic signed [31:0] acceleration;
		logic [30:0] distance;
	} in_item_t;

	typedef struct packed {
		logic [31:0] travel_time;
		logic saturated;
	} out_item_t;

	// Numerator source selected by the front end
	typedef enum logic [1:0] {
		MODE_CV,
		MODE_DIFF,
		MODE_ROOT
	} mode_t;

	// Classified request handed from front end to back end
	typedef struct packed {
		logic [63:0] rad;
		logic [31:0] base;
		logic [31:0] den;
		mode_t mode;
	} job_t;

	function automatic logic [31:0] mag32(input logic [31:0] raw);
		mag32 = raw[31] ? (~raw + 32'd1) : raw;
	endfunction

endpackage

// ===== sv/catt_front.sv =====
// Front end: splits signs, forms products, classifies the case and the radicand.
`timescale 1ns / 1ps
module catt_front (
	input  logic clk,
	input  logic arst_n,
	input  logic [catt_pkg::EPS_W-1:0] eps,
	input  logic push,
	output logic full,
	input  catt_pkg::in_item_t in_item,
	input  logic q_ready,
	output logic q_push,
	output catt_pkg::job_t q_data
);

	logic en;
	logic accept;
	logic [catt_pkg::EPS_W-1:0] eps_eff;
	logic [31:0] eps32;

	logic v_s1;
	logic vneg_s1;
	logic aneg_s1;
	logic [31:0] vmag_s1;
	logic [31:0] amag_s1;
	logic [30:0] dist_s1;

	logic cv;
	logic same;
	logic [31:0] den;

	logic v_s2;
	logic [63:0] vsq_s2;
	logic [62:0] ad_s2;
	logic cv_s2;
	logic same_s2;
	logic [31:0] den_s2;
	logic [31:0] vmag_s2;
	logic [30:0] dist_s2;

	logic [63:0] two_ad;
	logic [63:0] psum;
	logic [63:0] msub;

	// Advance while the output stage is empty or the queue takes it
	assign en = !v_s2 || q_ready;
	assign full = !en;
	assign accept = push && en;

	// Zero threshold acts as one
	assign eps_eff = (eps == '0) ? {{(catt_pkg::EPS_W-1){1'b0}}, 1'b1} : eps;
	assign eps32 = {{(32-catt_pkg::EPS_W){1'b0}}, eps_eff};

	// Stage 1: register magnitudes and signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vneg_s1 <= in_item.velocity[31];
			aneg_s1 <= in_item.acceleration[31];
			vmag_s1 <= catt_pkg::mag32(in_item.velocity);
			amag_s1 <= catt_pkg::mag32(in_item.acceleration);
			dist_s1 <= in_item.distance;
		end
	end

	// Classify and pick the divisor
	always_comb begin
		cv = amag_s1 < eps32;
		if (cv) begin
			den = (vmag_s1 < eps32) ? eps32 : vmag_s1;
		end else begin
			den = amag_s1;
		end
		same = (!aneg_s1 && (!vneg_s1 || vmag_s1 == '0)) ||
			(aneg_s1 && (vneg_s1 || vmag_s1 == '0));
	end

	// Stage 2: register products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vsq_s2 <= vmag_s1 * vmag_s1;
			ad_s2 <= amag_s1 * {1'b0, dist_s1};
			cv_s2 <= cv;
			same_s2 <= same;
			den_s2 <= den;
			vmag_s2 <= vmag_s1;
			dist_s2 <= dist_s1;
		end
	end

	// Form radicand and numerator mode
	assign two_ad = {ad_s2, 1'b0};
	assign psum = vsq_s2 + two_ad;
	assign msub = vsq_s2 - two_ad;

	always_comb begin
		q_data.den = den_s2;
		q_data.base = cv_s2 ? {1'b0, dist_s2} : vmag_s2;
		if (cv_s2) begin
			q_data.mode = catt_pkg::MODE_CV;
			q_data.rad = psum;
		end else if (same_s2) begin
			q_data.mode = catt_pkg::MODE_DIFF;
			q_data.rad = psum;
		end else if (vsq_s2 >= two_ad) begin
			q_data.mode = catt_pkg::MODE_DIFF;
			q_data.rad = msub;
		end else begin
			q_data.mode = catt_pkg::MODE_ROOT;
			q_data.rad = psum;
		end
	end

	assign q_push = v_s2 && q_ready;

endmodule

// ===== sv/catt_queue.sv =====
// Short request queue between front end and back end.
`timescale 1ns / 1ps
module catt_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  catt_pkg::job_t wdata,
	output logic ready,
	input  logic rd,
	output logic nonempty,
	output catt_pkg::job_t rdata
);

	catt_pkg::job_t mem_q [catt_pkg::QDEPTH];
	logic [catt_pkg::QAW-1:0] wptr_q;
	logic [catt_pkg::QAW-1:0] rptr_q;
	logic [catt_pkg::QAW:0] cnt_q;
	logic do_rd;

	assign ready = cnt_q != (catt_pkg::QAW+1)'(catt_pkg::QDEPTH);
	assign nonempty = cnt_q != '0;
	assign rdata = mem_q[rptr_q];
	assign do_rd = rd && nonempty;

	// Store requests
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({wr, do_rd})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/catt_back.sv =====
// Back end: pipelined square root, numerator select, pipelined divider, result register.
`timescale 1ns / 1ps
module catt_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	input  catt_pkg::job_t job,
	output logic job_take,
	output logic empty,
	input  logic pop,
	output catt_pkg::out_item_t out_item
);

	localparam int SQ = catt_pkg::SQ_STEPS;
	localparam int NW = 32 + FRAC_BITS;

	logic en;

	logic [SQ-1:0] sq_v_s;
	logic [63:0] sq_rad_s [SQ];
	logic [33:0] sq_rem_s [SQ];
	logic [31:0] sq_root_s [SQ];
	logic [31:0] sq_base_s [SQ];
	logic [31:0] sq_den_s [SQ];
	catt_pkg::mode_t sq_mode_s [SQ];

	logic [31:0] num0;
	logic nv_q;
	logic [NW-1:0] num_q;
	logic [31:0] nden_q;

	logic [NW-1:0] dv_s;
	logic [NW-1:0] dnum_s [NW];
	logic [31:0] drem_s [NW];
	logic [31:0] dq_s [NW];
	logic [NW-1:0] dsat_s;
	logic [31:0] dden_s [NW];

	logic ov_q;
	catt_pkg::out_item_t out_q;

	// Whole back end advances while the result register is free or popped
	assign en = !ov_q || pop;
	assign job_take = en && job_valid;
	assign empty = !ov_q;
	assign out_item = out_q;

	// Square root: one root bit per stage
	for (genvar g = 0; g < SQ; g++) begin : g_sq
		logic pv;
		logic [63:0] prad;
		logic [33:0] prem;
		logic [31:0] proot;
		logic [31:0] pbase;
		logic [31:0] pden;
		catt_pkg::mode_t pmode;
		logic [34:0] cand;
		logic [34:0] trial;
		logic [34:0] diff;
		logic ge;

		if (g == 0) begin : g_first
			assign pv = job_take;
			assign prad = job.rad;
			assign prem = '0;
			assign proot = '0;
			assign pbase = job.base;
			assign pden = job.den;
			assign pmode = job.mode;
		end else begin : g_next
			assign pv = sq_v_s[g-1];
			assign prad = sq_rad_s[g-1];
			assign prem = sq_rem_s[g-1];
			assign proot = sq_root_s[g-1];
			assign pbase = sq_base_s[g-1];
			assign pden = sq_den_s[g-1];
			assign pmode = sq_mode_s[g-1];
		end

		assign cand = {prem[32:0], prad[63:62]};
		assign trial = {1'b0, proot, 2'b01};
		assign ge = cand >= trial;
		assign diff = cand - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[g] <= 1'b0;
			end else if (en) begin
				sq_v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_s[g] <= {prad[61:0], 2'b00};
				sq_rem_s[g] <= ge ? diff[33:0] : cand[33:0];
				sq_root_s[g] <= {proot[30:0], ge};
				sq_base_s[g] <= pbase;
				sq_den_s[g] <= pden;
				sq_mode_s[g] <= pmode;
			end
		end
	end

	// Select the numerator
	always_comb begin
		case (sq_mode_s[SQ-1])
			catt_pkg::MODE_CV: num0 = sq_base_s[SQ-1];
			catt_pkg::MODE_DIFF: begin
				if (sq_root_s[SQ-1] >= sq_base_s[SQ-1]) begin
					num0 = sq_root_s[SQ-1] - sq_base_s[SQ-1];
				end else begin
					num0 = sq_base_s[SQ-1] - sq_root_s[SQ-1];
				end
			end
			default: num0 = sq_root_s[SQ-1];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q <= 1'b0;
		end else if (en) begin
			nv_q <= sq_v_s[SQ-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_q <= {num0, {FRAC_BITS{1'b0}}};
			nden_q <= sq_den_s[SQ-1];
		end
	end

	// Divider: one quotient bit per stage, overflow bits fold into the flag
	for (genvar g = 0; g < NW; g++) begin : g_div
		logic pv;
		logic [NW-1:0] pnum;
		logic [31:0] prem;
		logic [31:0] pq;
		logic psat;
		logic [31:0] pden;
		logic [32:0] cand;
		logic [32:0] diff;
		logic ge;

		if (g == 0) begin : g_first
			assign pv = nv_q;
			assign pnum = num_q;
			assign prem = '0;
			assign pq = '0;
			assign psat = 1'b0;
			assign pden = nden_q;
		end else begin : g_next
			assign pv = dv_s[g-1];
			assign pnum = dnum_s[g-1];
			assign prem = drem_s[g-1];
			assign pq = dq_s[g-1];
			assign psat = dsat_s[g-1];
			assign pden = dden_s[g-1];
		end

		assign cand = {prem, pnum[NW-1]};
		assign ge = cand >= {1'b0, pden};
		assign diff = cand - {1'b0, pden};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[g] <= 1'b0;
			end else if (en) begin
				dv_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dnum_s[g] <= {pnum[NW-2:0], 1'b0};
				drem_s[g] <= ge ? diff[31:0] : cand[31:0];
				dq_s[g] <= {pq[30:0], ge};
				dsat_s[g] <= psat | pq[31];
				dden_s[g] <= pden;
			end
		end
	end

	// Result register, saturate on overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= dv_s[NW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.travel_time <= dsat_s[NW-1] ? '1 : dq_s[NW-1];
			out_q.saturated <= dsat_s[NW-1];
		end
	end

endmodule

// ===== sv/constant_accel_travel_time_core.sv =====
// Top level of the constant-acceleration travel time core.
//
//  channel   handshake             payload
//  input     push / full           in_item  (velocity, acceleration, distance)
//  result    pop / empty           out_item (travel_time, saturated)
//  config    cfg_valid / cfg_ready cfg_data (epsilon threshold)
//
// One item per cycle sustained while results are popped; an accepted request passes
// the front end's stage 1 and stage 2 registers, the queue write, 32 root stages, the
// numerator register, 32 + FRAC_BITS divider stages and the result register.
// Reset empties the pipelines and queue and loads the threshold with 66.
// A held result stalls the back end; the 4-entry queue lets the front end keep
// accepting until it fills, then full rises.
`timescale 1ns / 1ps
module constant_accel_travel_time_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  catt_pkg::in_item_t in_item,
	output logic empty,
	input  logic pop,
	output catt_pkg::out_item_t out_item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [catt_pkg::EPS_W-1:0] cfg_data
);

	localparam int CAP = 2 + catt_pkg::QDEPTH + catt_pkg::SQ_STEPS + 1 + 32 + FRAC_BITS + 1;
	localparam int CW = $clog2(CAP + 1);

	logic [catt_pkg::EPS_W-1:0] eps_q;
	logic q_ready;
	logic q_push;
	catt_pkg::job_t q_wdata;
	logic q_nonempty;
	catt_pkg::job_t q_rdata;
	logic q_take;
	logic [CW-1:0] items_q;

	assign cfg_ready = 1'b1;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= catt_pkg::EPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			eps_q <= cfg_data;
		end
	end

	catt_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.eps(eps_q),
		.push(push),
		.full(full),
		.in_item(in_item),
		.q_ready(q_ready),
		.q_push(q_push),
		.q_data(q_wdata)
	);

	catt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_push),
		.wdata(q_wdata),
		.ready(q_ready),
		.rd(q_take),
		.nonempty(q_nonempty),
		.rdata(q_rdata)
	);

	catt_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(q_nonempty),
		.job(q_rdata),
		.job_take(q_take),
		.empty(empty),
		.pop(pop),
		.out_item(out_item)
	);

	// Track requests in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q <= '0;
		end else begin
			case ({push && !full, pop && !empty})
				2'b10: items_q <= items_q + 1'b1;
				2'b01: items_q <= items_q - 1'b1;
				default: items_q <= items_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.saturated |-> out_item.travel_time == 32'hFFFFFFFF)
		else $error("saturated result not at maximum");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> items_q != '0)
		else $error("result shown with no request in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		items_q <= CW'(CAP))
		else $error("more requests in flight than storage");
`endif

endmodule
